// ----- sv/sm4_pkg.sv -----
// ----------------------------------------------------------------------------
// SM4 block cipher package
// Shared widths, constants, the S-box table and the small helper functions
// used by the SM4 cipher unit and its submodules.
// ----------------------------------------------------------------------------
package sm4_pkg;

  // Field and counter widths.
  localparam int WordWidth     = 32;
  localparam int KeyWords      = 4;
  localparam int CfgIndexWidth = 8;
  localparam int RoundCount    = 32;
  localparam int RoundIdxWidth = $clog2(RoundCount);
  localparam logic [RoundIdxWidth-1:0] LastRound = RoundIdxWidth'(RoundCount - 1);

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [RoundIdxWidth-1:0] round_idx_t;

  // Command codes of an input beat.
  typedef enum logic {
    CmdEncrypt = 1'b0,
    CmdDecrypt = 1'b1
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CfgIndexWidth-1:0] {
    RegKeyWord0 = 8'd0,
    RegKeyWord1 = 8'd1,
    RegKeyWord2 = 8'd2,
    RegKeyWord3 = 8'd3
  } cfg_reg_t;

  // Which linear map the shared round unit applies.
  typedef enum logic {
    ModeKey  = 1'b0,
    ModeData = 1'b1
  } round_mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StExpand,
    StFetch,
    StRound,
    StFinish
  } seq_state_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic       load_block;
    logic       load_key;
    logic       expand;
    logic       expand_done;
    logic       round;
    logic       load_out;
    round_idx_t wr_addr;
    round_idx_t rd_addr;
  } seq_ctrl_t;

  // System parameter FK.
  localparam word_t FK [KeyWords] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  // Standard SM4 S-box.
  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Nonlinear substitution of all four bytes of a word.
  function automatic word_t sub_word(input word_t x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // Key schedule constant CK for round i: byte j is (4i + j) * 7 mod 256.
  function automatic word_t ck_word(input round_idx_t i);
    word_t      w;
    logic [7:0] base;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      base = {1'b0, i, 2'(j)};
      w    = {w[23:0], 8'(base * 8'd7)};
    end
    return w;
  endfunction

endpackage

// ----- sv/sm4_channels.sv -----
// ----------------------------------------------------------------------------
// SM4 channel interfaces
// Valid/ready channels for input blocks, result blocks and key configuration.
// ----------------------------------------------------------------------------

// Input block channel: one beat carries a command and a 128-bit block.
interface sm4_in_if;
  import sm4_pkg::*;
  logic  valid;
  logic  ready;
  logic  cmd;
  word_t block_word_0;
  word_t block_word_1;
  word_t block_word_2;
  word_t block_word_3;

  modport source (output valid, cmd, block_word_0, block_word_1, block_word_2, block_word_3,
                  input ready);
  modport sink (input valid, cmd, block_word_0, block_word_1, block_word_2, block_word_3,
                output ready);
endinterface

// Result channel: one beat carries the four result words.
interface sm4_out_if;
  import sm4_pkg::*;
  logic  valid;
  logic  ready;
  word_t out_word_0;
  word_t out_word_1;
  word_t out_word_2;
  word_t out_word_3;

  modport source (output valid, out_word_0, out_word_1, out_word_2, out_word_3,
                  input ready);
  modport sink (input valid, out_word_0, out_word_1, out_word_2, out_word_3,
                output ready);
endinterface

// Configuration write channel: one beat writes one register.
interface sm4_cfg_if;
  import sm4_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  word_t                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/sm4_round_unit.sv -----
// ----------------------------------------------------------------------------
// SM4 shared round function
// Computes a ^ L(S(b)) with either the key schedule map or the data map.
// ----------------------------------------------------------------------------
module sm4_round_unit (
  input  sm4_pkg::round_mode_t mode,
  input  sm4_pkg::word_t       a,
  input  sm4_pkg::word_t       b,
  output sm4_pkg::word_t       y
);
  import sm4_pkg::*;

  word_t s;
  word_t l;

  // Byte substitution through the S-box.
  assign s = sub_word(b);

  // Linear diffusion; the rotations are plain rewiring.
  always_comb begin
    case (mode)
      ModeKey:  l = s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};
      ModeData: l = s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]}
                      ^ {s[13:0], s[31:14]} ^ {s[7:0], s[31:8]};
      default:  l = s;
    endcase
  end

  assign y = a ^ l;

endmodule

// ----- sv/sm4_key_store.sv -----
// ----------------------------------------------------------------------------
// SM4 round key store
// Single write, single read memory holding the 32 expanded round keys.
// ----------------------------------------------------------------------------
module sm4_key_store (
  input  logic                clk,
  input  logic                wr_en,
  input  sm4_pkg::round_idx_t wr_addr,
  input  sm4_pkg::word_t      wr_data,
  input  sm4_pkg::round_idx_t rd_addr,
  output sm4_pkg::word_t      rd_data
);
  import sm4_pkg::*;

  word_t mem [RoundCount];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/sm4_seq.sv -----
// ----------------------------------------------------------------------------
// SM4 sequencer
// Steps key expansion, round key prefetch, the 32 data rounds and the
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module sm4_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               key_stale,
  input  logic               decrypt,
  input  logic               out_free,
  output sm4_pkg::seq_ctrl_t ctrl
);
  import sm4_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  round_idx_t cnt;
  round_idx_t cnt_next;
  round_idx_t cnt_inc;

  // Round key address for a given round; decryption walks the keys backward.
  function automatic round_idx_t key_addr(input logic dec, input round_idx_t r);
    return dec ? ~r : r;
  endfunction

  assign cnt_inc = cnt + 1'b1;

  // State and round counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    ctrl       = '0;
    case (state)
      StIdle: begin
        // No beat is taken while reset is held.
        in_ready = !rst;
        cnt_next = '0;
        if (in_valid && !rst) begin
          ctrl.load_block = 1'b1;
          if (key_stale) begin
            ctrl.load_key = 1'b1;
            state_next    = StExpand;
          end else begin
            state_next = StFetch;
          end
        end
      end
      StExpand: begin
        ctrl.expand  = 1'b1;
        ctrl.wr_addr = cnt;
        if (cnt == LastRound) begin
          ctrl.expand_done = 1'b1;
          cnt_next         = '0;
          state_next       = StFetch;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      StFetch: begin
        ctrl.rd_addr = key_addr(decrypt, '0);
        cnt_next     = '0;
        state_next   = StRound;
      end
      StRound: begin
        ctrl.round   = 1'b1;
        ctrl.rd_addr = key_addr(decrypt, cnt_inc);
        if (cnt == LastRound) begin
          cnt_next   = '0;
          state_next = StFinish;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      StFinish: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

endmodule

// ----- sv/sm4_block_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// SM4 block cipher unit
// Iterative SM4 encrypt/decrypt of one 128-bit block per input beat.
// ----------------------------------------------------------------------------
// One block is worked at a time through a single shared round unit (four
// S-box lookups and a linear map), one round per clock. After a block is
// accepted the unit prefetches the first round key from the key store, runs
// the 32 data rounds, moves the result into the output register and returns
// to idle. The first block after reset or after any key register write
// also expands the key first, which runs the key schedule through the same
// round unit and writes each round key to the key store; later blocks reuse
// the stored round keys. The result waits in its own register, so the next
// block can be accepted before the result beat is taken, and the unit stalls
// only when a finished block finds the output register still full.
// ----------------------------------------------------------------------------
module sm4_block_cipher_unit (
  input  logic clk,
  input  logic rst,
  sm4_in_if.sink    blk_in,
  sm4_out_if.source blk_out,
  sm4_cfg_if.sink   cfg
);
  import sm4_pkg::*;

  word_t       key_word [KeyWords];
  logic        key_stale;
  word_t       k_word [KeyWords];
  word_t       x_word [KeyWords];
  logic        decrypt;
  logic        out_valid;
  word_t       out_word [KeyWords];
  seq_ctrl_t   ctrl;
  logic        out_free;
  word_t       rk;
  word_t       unit_a;
  word_t       unit_b;
  word_t       unit_y;
  round_mode_t mode;
  logic        cfg_hit;

  // Configuration writes are taken outside reset; indexes past the key are dropped.
  assign cfg.ready = !rst;
  assign cfg_hit   = cfg.valid && cfg.ready &&
                     (cfg.index inside {RegKeyWord0, RegKeyWord1, RegKeyWord2, RegKeyWord3});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyWords; i++) begin
        key_word[i] <= '0;
      end
    end else if (cfg_hit) begin
      key_word[cfg.index[1:0]] <= cfg.data;
    end
  end

  // The stored round keys are stale after reset and after a key write.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_stale <= 1'b1;
    end else if (cfg_hit) begin
      key_stale <= 1'b1;
    end else if (ctrl.expand_done) begin
      key_stale <= 1'b0;
    end
  end

  // Output register handshake.
  assign out_free = !out_valid || blk_out.ready;

  sm4_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (blk_in.valid),
    .in_ready  (blk_in.ready),
    .key_stale (key_stale),
    .decrypt   (decrypt),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  // Shared round unit input selection.
  always_comb begin
    if (ctrl.expand) begin
      mode   = ModeKey;
      unit_a = k_word[0];
      unit_b = k_word[1] ^ k_word[2] ^ k_word[3] ^ ck_word(ctrl.wr_addr);
    end else begin
      mode   = ModeData;
      unit_a = x_word[0];
      unit_b = x_word[1] ^ x_word[2] ^ x_word[3] ^ rk;
    end
  end

  sm4_round_unit u_round (
    .mode (mode),
    .a    (unit_a),
    .b    (unit_b),
    .y    (unit_y)
  );

  sm4_key_store u_keys (
    .clk     (clk),
    .wr_en   (ctrl.expand),
    .wr_addr (ctrl.wr_addr),
    .wr_data (unit_y),
    .rd_addr (ctrl.rd_addr),
    .rd_data (rk)
  );

  // Key schedule shift register, seeded with the key XOR FK.
  always_ff @(posedge clk) begin
    if (ctrl.load_key) begin
      for (int i = 0; i < KeyWords; i++) begin
        k_word[i] <= key_word[i] ^ FK[i];
      end
    end else if (ctrl.expand) begin
      k_word[0] <= k_word[1];
      k_word[1] <= k_word[2];
      k_word[2] <= k_word[3];
      k_word[3] <= unit_y;
    end
  end

  // Data shift register and the command of the block in work.
  always_ff @(posedge clk) begin
    if (ctrl.load_block) begin
      x_word[0] <= blk_in.block_word_0;
      x_word[1] <= blk_in.block_word_1;
      x_word[2] <= blk_in.block_word_2;
      x_word[3] <= blk_in.block_word_3;
      decrypt   <= (blk_in.cmd == CmdDecrypt);
    end else if (ctrl.round) begin
      x_word[0] <= x_word[1];
      x_word[1] <= x_word[2];
      x_word[2] <= x_word[3];
      x_word[3] <= unit_y;
    end
  end

  // Result beat holds the last four round words in reverse order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (blk_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      for (int i = 0; i < KeyWords; i++) begin
        out_word[i] <= x_word[KeyWords - 1 - i];
      end
    end
  end

  assign blk_out.valid      = out_valid;
  assign blk_out.out_word_0 = out_word[0];
  assign blk_out.out_word_1 = out_word[1];
  assign blk_out.out_word_2 = out_word[2];
  assign blk_out.out_word_3 = out_word[3];

endmodule

// ----- tb/sm4_block_cipher_unit_test.sv -----
// ----------------------------------------------------------------------------
// SM4 block cipher unit testbench
// Drives key register writes and cipher blocks into the unit. A scoreboard
// predicts every result from its own SM4 key schedule and round function,
// and compares the result beats word by word in order. Directed blocks cover
// the published test vector, all-zero and all-one keys and blocks, partial
// key changes and ignored register indexes. Random phases follow, each under
// a new key and one of four patterns of sender gaps and receiver stalls, one
// of them with a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module sm4_block_cipher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sm4_pkg::*;

  localparam int ResetCycles  = 6;
  localparam int RandomItems  = 1100;
  localparam int RandomPhases = 8;
  localparam int HoldCycles   = 400;
  localparam int DrainCycles  = 80;
  localparam int CycleLimit   = 800000;

  // Four words of a block; word i sits at index i.
  typedef logic [3:0][WordWidth-1:0] quad_t;

  // One write on the configuration channel.
  typedef struct packed {
    logic [CfgIndexWidth-1:0] index;
    word_t                    data;
  } cfg_beat_t;

  // Mirrors the key registers, computes the expected result of every
  // accepted block and checks result beats against them in order.
  class sm4_scoreboard;
    word_t       key_words[KeyWords];
    quad_t       expected_blocks[$];
    int unsigned failures;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      failures = 0;
    endfunction

    // Indexes past the last key word are dropped by the unit.
    function void write_reg(logic [CfgIndexWidth-1:0] index, word_t data);
      if (index < KeyWords) key_words[index] = data;
    endfunction

    function word_t rotl(word_t x, int n);
      return (x << n) | (x >> (WordWidth - n));
    endfunction

    function word_t substitute(word_t x);
      word_t y;
      for (int b = 0; b < 4; b++) y[8*b +: 8] = SBOX[x[8*b +: 8]];
      return y;
    endfunction

    // Byte j of the schedule constant for round i is (4i + j) * 7 mod 256.
    function word_t schedule_const(int i);
      word_t w;
      w = '0;
      for (int j = 0; j < 4; j++) w = {w[23:0], 8'((4 * i + j) * 7)};
      return w;
    endfunction

    function word_t key_mix(word_t x);
      word_t b;
      b = substitute(x);
      return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    function word_t data_mix(word_t x);
      word_t b;
      b = substitute(x);
      return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    // Full key expansion followed by 32 data rounds; decryption walks the
    // round keys backward. The result comes out in reversed word order.
    function quad_t cipher(cmd_t op, quad_t blk);
      word_t k[4];
      word_t rk[RoundCount];
      word_t x[4];
      word_t sel;
      quad_t res;
      for (int i = 0; i < 4; i++) k[i] = key_words[i] ^ FK[i];
      for (int i = 0; i < RoundCount; i++) begin
        k[i % 4] = k[i % 4] ^ key_mix(k[(i + 1) % 4] ^ k[(i + 2) % 4] ^
                                      k[(i + 3) % 4] ^ schedule_const(i));
        rk[i] = k[i % 4];
      end
      for (int i = 0; i < 4; i++) x[i] = blk[i];
      for (int i = 0; i < RoundCount; i++) begin
        sel = (op == CmdDecrypt) ? rk[RoundCount - 1 - i] : rk[i];
        x[i % 4] = x[i % 4] ^ data_mix(x[(i + 1) % 4] ^ x[(i + 2) % 4] ^
                                       x[(i + 3) % 4] ^ sel);
      end
      for (int i = 0; i < 4; i++) res[i] = x[3 - i];
      return res;
    endfunction

    function void note_block(cmd_t op, quad_t blk);
      expected_blocks.push_back(cipher(op, blk));
    endfunction

    function void check_block(quad_t got);
      quad_t want;
      if (expected_blocks.size() == 0) begin
        $display("%0t: result beat with none expected, got %032h", $time, got);
        failures++;
        return;
      end
      want = expected_blocks.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[i] !== want[i]) begin
          $display("%0t: out_word_%0d mismatch, expected %08h, actual %08h",
                   $time, i, want[i], got[i]);
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  sm4_in_if  blk_in();
  sm4_out_if blk_out();
  sm4_cfg_if cfg();

  sm4_block_cipher_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .blk_in  (blk_in),
    .blk_out (blk_out),
    .cfg     (cfg)
  );

  sm4_scoreboard sb;
  int            send_idle_pct;
  int            recv_stall_pct;
  logic          hold_off;
  int unsigned   cycle_count;

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: check every accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    if (rst) begin
      blk_out.ready <= 1'b0;
    end else begin
      if (blk_out.valid && blk_out.ready) begin
        sb.check_block({blk_out.out_word_3, blk_out.out_word_2,
                        blk_out.out_word_1, blk_out.out_word_0});
      end
      if (hold_off) begin
        blk_out.ready <= 1'b0;
      end else begin
        blk_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one block, with a random gap first when the sender idles. Valid
  // stays high after the beat so back-to-back blocks need no extra edge.
  task automatic send_block(cmd_t op, quad_t blk);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      blk_in.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    blk_in.valid        <= 1'b1;
    blk_in.cmd          <= op;
    blk_in.block_word_0 <= blk[0];
    blk_in.block_word_1 <= blk[1];
    blk_in.block_word_2 <= blk[2];
    blk_in.block_word_3 <= blk[3];
    @(posedge clk);
    while (!blk_in.ready) @(posedge clk);
    sb.note_block(op, blk);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    blk_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register writes, one beat each, only while the unit is idle.
  task automatic write_regs(input cfg_beat_t beats[$]);
    foreach (beats[i]) begin
      cfg.valid <= 1'b1;
      cfg.index <= beats[i].index;
      cfg.data  <= beats[i].data;
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
      sb.write_reg(beats[i].index, beats[i].data);
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic load_key(quad_t key);
    cfg_beat_t beats[$];
    beats.push_back('{RegKeyWord0, key[0]});
    beats.push_back('{RegKeyWord1, key[1]});
    beats.push_back('{RegKeyWord2, key[2]});
    beats.push_back('{RegKeyWord3, key[3]});
    write_regs(beats);
  endtask

  // Random word, biased toward the all-zero and all-one extremes.
  function automatic word_t rand_word();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  function automatic quad_t rand_quad();
    quad_t q;
    for (int i = 0; i < 4; i++) q[i] = rand_word();
    return q;
  endfunction

  initial begin
    cfg_beat_t beats[$];
    quad_t     std_block;
    quad_t     std_cipher;
    quad_t     key;
    int        per_phase;

    sb = new();
    cycle_count         <= 0;
    rst                 <= 1'b1;
    hold_off            <= 1'b0;
    recv_stall_pct      <= 0;
    send_idle_pct       = 0;
    blk_in.valid        <= 1'b0;
    blk_in.cmd          <= CmdEncrypt;
    blk_in.block_word_0 <= '0;
    blk_in.block_word_1 <= '0;
    blk_in.block_word_2 <= '0;
    blk_in.block_word_3 <= '0;
    cfg.valid           <= 1'b0;
    cfg.index           <= '0;
    cfg.data            <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Key registers at their reset value of zero.
    send_block(CmdEncrypt, '0);
    send_block(CmdEncrypt, '1);
    send_block(CmdDecrypt, '0);
    send_block(CmdDecrypt, '1);
    drain_results();

    // Published test vector: key and plaintext are the same 128 bits.
    std_block  = {32'h76543210, 32'hfedcba98, 32'h89abcdef, 32'h01234567};
    std_cipher = {32'h536e4246, 32'h86b3e94f, 32'hd206965e, 32'h681edf34};
    load_key(std_block);
    if (sb.cipher(CmdEncrypt, std_block) !== std_cipher) begin
      $display("%0t: predictor test vector mismatch, expected %032h, actual %032h",
               $time, std_cipher, sb.cipher(CmdEncrypt, std_block));
      sb.failures++;
    end
    send_block(CmdEncrypt, std_block);
    send_block(CmdDecrypt, std_cipher);
    send_block(CmdEncrypt, {4{32'h55555555}});
    send_block(CmdDecrypt, {4{32'haaaaaaaa}});
    send_block(CmdEncrypt, '0);
    send_block(CmdDecrypt, '1);
    drain_results();

    // All-one key.
    load_key('1);
    send_block(CmdEncrypt, '0);
    send_block(CmdDecrypt, '0);
    send_block(CmdEncrypt, '1);
    send_block(CmdDecrypt, '1);
    drain_results();

    // Change one key word; the writes past the last key word are dropped.
    beats = {};
    beats.push_back('{RegKeyWord2, 32'h0f1e2d3c});
    beats.push_back('{8'(KeyWords), 32'hdeadbeef});
    beats.push_back('{'1, 32'h12345678});
    write_regs(beats);
    send_block(CmdEncrypt, std_block);
    send_block(CmdDecrypt, std_block);
    drain_results();

    // A dropped write alone leaves the key as it was.
    beats = {};
    beats.push_back('{8'($urandom_range(255, KeyWords)), $urandom});
    write_regs(beats);
    send_block(CmdEncrypt, std_block);
    send_block(CmdDecrypt, std_cipher);
    drain_results();

    // Random phases, each under a new key and one of four gap patterns.
    per_phase = RandomItems / RandomPhases;
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) begin
        load_key('0);
      end else if (p == 1) begin
        load_key('1);
      end else if (p == 5) begin
        beats = {};
        beats.push_back('{8'($urandom_range(KeyWords - 1)), $urandom});
        beats.push_back('{8'($urandom_range(255, KeyWords)), $urandom});
        write_regs(beats);
      end else begin
        for (int i = 0; i < 4; i++) key[i] = $urandom;
        load_key(key);
      end

      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 78;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct <= 29;
        end
      endcase

      // Long receiver hold-off while blocks keep coming, so the unit backs up.
      if (p == 4) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (HoldCycles) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end

      for (int n = 0; n < per_phase; n++) begin
        send_block(cmd_t'($urandom_range(1)), rand_quad());
      end
      drain_results();
    end

    repeat (DrainCycles) @(posedge clk);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
